@@ sv/irm_pkg.sv @@
// ----------------------------------------------------------------------------
// irm_pkg - shared definitions for the image rotation mapper
// Field widths, fixed-point format, register indexes, the command beat passed
// from the mapping front end to the frame-store back end, and address helper.
// ----------------------------------------------------------------------------
package irm_pkg;

    localparam int FRAC_BITS   = 14;
    localparam int MAX_DIM     = 256;
    localparam int STORE_DEPTH = 65536;

    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int COORD_W = 9;
    localparam int AFULL_W = COORD_W + DIM_W + 1;
    localparam int TRIG_W  = 16;
    localparam int SIZE_W  = 9;
    localparam int PIX_W   = 24;
    localparam int POS_W   = 11;
    localparam int DEST_W  = 10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 72;

    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_COS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [PIX_W-1:0] PIX_WHITE = {PIX_W{1'b1}};

    typedef struct packed {
        logic              is_fetch;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
        logic              in_src;
        logic [POS_W-1:0]  sx;
        logic [POS_W-1:0]  sy;
        logic [DEST_W-1:0] wd;
        logic [DEST_W-1:0] hd;
    } cmd_t;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y);
        logic [AFULL_W-1:0] full;
        full = ({{(AFULL_W-COORD_W){1'b0}}, y} << DIM_W)
             + {{(AFULL_W-COORD_W){1'b0}}, x};
        return full[ADDR_W-1:0];
    endfunction

endpackage

@@ sv/irm_front.sv @@
// ----------------------------------------------------------------------------
// irm_front - configuration registers and inverse-mapping pipeline
// Accepts input beats, checks write bounds, derives destination size and maps
// fetch coordinates back to the source through five register stages. Input
// is admitted only while the command queue has room for every beat in flight.
// ----------------------------------------------------------------------------
module irm_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [irm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [irm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [irm_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tuser,
    input  logic [irm_pkg::QCNT_W-1:0]       q_count,
    output logic                             q_push,
    output irm_pkg::cmd_t                    q_cmd
);

    localparam int DPROD_W = irm_pkg::SIZE_W + irm_pkg::TRIG_W;
    localparam int DSUM_W  = DPROD_W + 1;
    localparam int DCEIL_W = DSUM_W - irm_pkg::FRAC_BITS;
    localparam int DELTA_W = irm_pkg::COORD_W + 2;
    localparam int PROD_W  = irm_pkg::TRIG_W + DELTA_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int CEIL_W  = SUM_W - irm_pkg::FRAC_BITS;
    localparam int DEST_MAX  = (1 << irm_pkg::DEST_W) - 1;
    localparam int ROUND_ADD = (1 << irm_pkg::FRAC_BITS) - 1;

    typedef struct packed {
        logic                         op;
        logic                         wr_en;
        logic [irm_pkg::ADDR_W-1:0]   addr;
        logic [irm_pkg::PIX_W-1:0]    pix;
    } carry_t;

    logic signed [irm_pkg::TRIG_W-1:0] cos_reg, sin_reg;
    logic [irm_pkg::SIZE_W-1:0]        width_reg, height_reg;
    logic [irm_pkg::SIZE_W-1:0]        w_eff, h_eff;
    logic [irm_pkg::TRIG_W-1:0]        abs_cos, abs_sin;

    logic [DPROD_W-1:0]         dp_wc_reg, dp_hs_reg, dp_ws_reg, dp_hc_reg;
    logic [irm_pkg::SIZE_W-1:0] half_w_reg, half_h_reg;
    logic [DSUM_W-1:0]          wd_sum, hd_sum;
    logic [DCEIL_W-1:0]         wd_ceil, hd_ceil;
    logic [irm_pkg::DEST_W-1:0] wd_reg, hd_reg;
    logic [SUM_W-1:0]           offx_reg, offy_reg;

    logic                          accept;
    logic                          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                          op1_reg;
    logic [irm_pkg::COORD_W-1:0]   x1_reg, y1_reg, x2_reg, y2_reg;
    logic [irm_pkg::PIX_W-1:0]     pix1_reg;
    carry_t                        c2_reg, c3_reg, c4_reg, c5_reg;
    logic signed [DELTA_W-1:0]     di3_reg, dj3_reg;
    logic signed [PROD_W-1:0]      pcx4_reg, psy4_reg, psx4_reg, pcy4_reg;
    logic signed [SUM_W-1:0]       sumx, sumy;
    logic signed [CEIL_W-1:0]      bx5_reg, by5_reg;
    logic [irm_pkg::DEST_W-1:0]    wd3_reg, hd3_reg, wd4_reg, hd4_reg, wd5_reg, hd5_reg;
    logic [2:0]                    inflight;
    logic                          is_fetch, inside_x, inside_y;

    function automatic logic [irm_pkg::POS_W-1:0] sat_pos(input logic signed [CEIL_W-1:0] v);
        logic [CEIL_W-irm_pkg::POS_W:0] top;
        top = v[CEIL_W-1:irm_pkg::POS_W-1];
        if ((&top) || !(|top)) begin
            return v[irm_pkg::POS_W-1:0];
        end else if (v[CEIL_W-1]) begin
            return {1'b1, {(irm_pkg::POS_W-1){1'b0}}};
        end else begin
            return {1'b0, {(irm_pkg::POS_W-1){1'b1}}};
        end
    endfunction

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg    <= irm_pkg::TRIG_W'(1 << irm_pkg::FRAC_BITS);
            sin_reg    <= '0;
            width_reg  <= irm_pkg::SIZE_W'(256);
            height_reg <= irm_pkg::SIZE_W'(256);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                irm_pkg::REG_COS:    cos_reg    <= cfg_wdata[irm_pkg::TRIG_W-1:0];
                irm_pkg::REG_SIN:    sin_reg    <= cfg_wdata[irm_pkg::TRIG_W-1:0];
                irm_pkg::REG_WIDTH:  width_reg  <= cfg_wdata[irm_pkg::SIZE_W-1:0];
                irm_pkg::REG_HEIGHT: height_reg <= cfg_wdata[irm_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_eff = (width_reg > irm_pkg::SIZE_W'(irm_pkg::MAX_DIM))
                 ? irm_pkg::SIZE_W'(irm_pkg::MAX_DIM) : width_reg;
    assign h_eff = (height_reg > irm_pkg::SIZE_W'(irm_pkg::MAX_DIM))
                 ? irm_pkg::SIZE_W'(irm_pkg::MAX_DIM) : height_reg;
    assign abs_cos = cos_reg[irm_pkg::TRIG_W-1] ? irm_pkg::TRIG_W'(-cos_reg) : cos_reg;
    assign abs_sin = sin_reg[irm_pkg::TRIG_W-1] ? irm_pkg::TRIG_W'(-sin_reg) : sin_reg;

    // destination size and centering offsets, two stages behind the registers
    always_ff @(posedge aclk) begin
        dp_wc_reg  <= {{irm_pkg::TRIG_W{1'b0}}, w_eff} * {{irm_pkg::SIZE_W{1'b0}}, abs_cos};
        dp_hs_reg  <= {{irm_pkg::TRIG_W{1'b0}}, h_eff} * {{irm_pkg::SIZE_W{1'b0}}, abs_sin};
        dp_ws_reg  <= {{irm_pkg::TRIG_W{1'b0}}, w_eff} * {{irm_pkg::SIZE_W{1'b0}}, abs_sin};
        dp_hc_reg  <= {{irm_pkg::TRIG_W{1'b0}}, h_eff} * {{irm_pkg::SIZE_W{1'b0}}, abs_cos};
        half_w_reg <= w_eff >> 1;
        half_h_reg <= h_eff >> 1;
    end

    assign wd_sum  = {1'b0, dp_wc_reg} + {1'b0, dp_hs_reg} + DSUM_W'(ROUND_ADD);
    assign hd_sum  = {1'b0, dp_ws_reg} + {1'b0, dp_hc_reg} + DSUM_W'(ROUND_ADD);
    assign wd_ceil = wd_sum[DSUM_W-1:irm_pkg::FRAC_BITS];
    assign hd_ceil = hd_sum[DSUM_W-1:irm_pkg::FRAC_BITS];

    always_ff @(posedge aclk) begin
        wd_reg   <= (wd_ceil > DCEIL_W'(DEST_MAX)) ? irm_pkg::DEST_W'(DEST_MAX)
                                                  : wd_ceil[irm_pkg::DEST_W-1:0];
        hd_reg   <= (hd_ceil > DCEIL_W'(DEST_MAX)) ? irm_pkg::DEST_W'(DEST_MAX)
                                                  : hd_ceil[irm_pkg::DEST_W-1:0];
        offx_reg <= ({{(SUM_W-irm_pkg::SIZE_W){1'b0}}, half_w_reg} << irm_pkg::FRAC_BITS)
                  + SUM_W'(ROUND_ADD);
        offy_reg <= ({{(SUM_W-irm_pkg::SIZE_W){1'b0}}, half_h_reg} << irm_pkg::FRAC_BITS)
                  + SUM_W'(ROUND_ADD);
    end

    // admission by credit: every beat in flight has a queue slot
    assign inflight = {2'b0, v1_reg} + {2'b0, v2_reg} + {2'b0, v3_reg}
                    + {2'b0, v4_reg} + {2'b0, v5_reg};
    assign s_tready = ({1'b0, inflight} + q_count) < irm_pkg::QCNT_W'(irm_pkg::QDEPTH);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        // stage 1: capture beat
        op1_reg  <= s_tuser;
        x1_reg   <= s_tdata[irm_pkg::COORD_W-1:0];
        y1_reg   <= s_tdata[2*irm_pkg::COORD_W-1:irm_pkg::COORD_W];
        pix1_reg <= s_tdata[2*irm_pkg::COORD_W+irm_pkg::PIX_W-1:2*irm_pkg::COORD_W];
        // stage 2: write bounds and address
        c2_reg.op    <= op1_reg;
        c2_reg.wr_en <= (x1_reg < w_eff) && (y1_reg < h_eff);
        c2_reg.addr  <= irm_pkg::store_addr(x1_reg, y1_reg);
        c2_reg.pix   <= pix1_reg;
        x2_reg       <= x1_reg;
        y2_reg       <= y1_reg;
        // stage 3: offsets from destination center
        c3_reg  <= c2_reg;
        di3_reg <= $signed({2'b00, x2_reg}) - $signed({2'b00, wd_reg[irm_pkg::DEST_W-1:1]});
        dj3_reg <= $signed({2'b00, y2_reg}) - $signed({2'b00, hd_reg[irm_pkg::DEST_W-1:1]});
        wd3_reg <= wd_reg;
        hd3_reg <= hd_reg;
        // stage 4: rotation products
        c4_reg   <= c3_reg;
        pcx4_reg <= cos_reg * di3_reg;
        psy4_reg <= sin_reg * dj3_reg;
        psx4_reg <= sin_reg * di3_reg;
        pcy4_reg <= cos_reg * dj3_reg;
        wd4_reg  <= wd3_reg;
        hd4_reg  <= hd3_reg;
        // stage 5: sum and ceiling
        c5_reg  <= c4_reg;
        bx5_reg <= sumx[SUM_W-1:irm_pkg::FRAC_BITS];
        by5_reg <= sumy[SUM_W-1:irm_pkg::FRAC_BITS];
        wd5_reg <= wd4_reg;
        hd5_reg <= hd4_reg;
    end

    assign sumx = SUM_W'(pcx4_reg) + SUM_W'(psy4_reg) + $signed(offx_reg);
    assign sumy = SUM_W'(pcy4_reg) - SUM_W'(psx4_reg) + $signed(offy_reg);

    assign is_fetch = (c5_reg.op == irm_pkg::OP_FETCH);
    assign inside_x = !bx5_reg[CEIL_W-1]
                   && (bx5_reg[CEIL_W-2:0] < {{(CEIL_W-1-irm_pkg::SIZE_W){1'b0}}, w_eff});
    assign inside_y = !by5_reg[CEIL_W-1]
                   && (by5_reg[CEIL_W-2:0] < {{(CEIL_W-1-irm_pkg::SIZE_W){1'b0}}, h_eff});

    assign q_push = v5_reg;

    always_comb begin
        q_cmd.is_fetch = is_fetch;
        q_cmd.wr_en    = c5_reg.wr_en;
        q_cmd.addr     = is_fetch ? irm_pkg::store_addr(bx5_reg[irm_pkg::COORD_W-1:0],
                                                        by5_reg[irm_pkg::COORD_W-1:0])
                                  : c5_reg.addr;
        q_cmd.pix      = c5_reg.pix;
        q_cmd.in_src   = is_fetch && inside_x && inside_y;
        q_cmd.sx       = is_fetch ? sat_pos(bx5_reg) : '0;
        q_cmd.sy       = is_fetch ? sat_pos(by5_reg) : '0;
        q_cmd.wd       = wd5_reg;
        q_cmd.hd       = hd5_reg;
    end

endmodule

@@ sv/irm_queue.sv @@
// ----------------------------------------------------------------------------
// irm_queue - command queue between mapping front end and frame-store back end
// Small register FIFO; the front end never pushes beyond its credit.
// ----------------------------------------------------------------------------
module irm_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  irm_pkg::cmd_t                 push_cmd,
    input  logic                          pop,
    output logic                          head_valid,
    output irm_pkg::cmd_t                 head_cmd,
    output logic [irm_pkg::QCNT_W-1:0]    count
);

    irm_pkg::cmd_t                 entry_reg [irm_pkg::QDEPTH];
    logic [irm_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [irm_pkg::QCNT_W-1:0]    count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_comb begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

@@ sv/irm_back.sv @@
// ----------------------------------------------------------------------------
// irm_back - frame store and result output
// Pops commands, writes or reads the frame store through one port, and holds
// results in a two-entry output buffer; under stall the queue drains until it fills.
// ----------------------------------------------------------------------------
module irm_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  irm_pkg::cmd_t                    q_head,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [irm_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tuser
);

    localparam int PAD_W = irm_pkg::M_TDATA_W - irm_pkg::PIX_W - 2*irm_pkg::POS_W
                         - 2*irm_pkg::DEST_W;

    typedef struct packed {
        logic [irm_pkg::DEST_W-1:0] hd;
        logic [irm_pkg::DEST_W-1:0] wd;
        logic [irm_pkg::POS_W-1:0]  sy;
        logic [irm_pkg::POS_W-1:0]  sx;
        logic                       in_src;
        logic [irm_pkg::PIX_W-1:0]  pixel;
    } res_t;

    logic [irm_pkg::PIX_W-1:0] store_mem [irm_pkg::STORE_DEPTH];
    logic [irm_pkg::PIX_W-1:0] rd_data_reg;
    logic                      mem_we, mem_re;

    logic          b1_valid_reg;
    irm_pkg::cmd_t b1_cmd_reg;
    res_t          b1_res;

    res_t          obuf_reg [2];
    logic          o_wr_ptr_reg, o_rd_ptr_reg;
    logic [1:0]    o_cnt_reg, o_cnt_next;
    logic          take, room;

    assign take   = m_tvalid && m_tready;
    assign room   = ({1'b0, o_cnt_reg} + {2'b0, b1_valid_reg}) < 3'd2;
    assign q_pop  = q_valid && (room || take);
    assign mem_we = q_pop && !q_head.is_fetch && q_head.wr_en;
    assign mem_re = q_pop && q_head.is_fetch && q_head.in_src;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[q_head.addr] <= q_head.pix;
        end
        if (mem_re) begin
            rd_data_reg <= store_mem[q_head.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
        end else begin
            b1_valid_reg <= q_pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            b1_cmd_reg <= q_head;
        end
    end

    always_comb begin
        b1_res.hd     = b1_cmd_reg.hd;
        b1_res.wd     = b1_cmd_reg.wd;
        b1_res.sy     = b1_cmd_reg.sy;
        b1_res.sx     = b1_cmd_reg.sx;
        b1_res.in_src = b1_cmd_reg.in_src;
        if (!b1_cmd_reg.is_fetch) begin
            b1_res.pixel = '0;
        end else if (b1_cmd_reg.in_src) begin
            b1_res.pixel = rd_data_reg;
        end else begin
            b1_res.pixel = irm_pkg::PIX_WHITE;
        end
    end

    always_ff @(posedge aclk) begin
        if (b1_valid_reg) begin
            obuf_reg[o_wr_ptr_reg] <= b1_res;
        end
    end

    always_comb begin
        case ({b1_valid_reg, take})
            2'b10:   o_cnt_next = o_cnt_reg + 1'b1;
            2'b01:   o_cnt_next = o_cnt_reg - 1'b1;
            default: o_cnt_next = o_cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_wr_ptr_reg <= 1'b0;
            o_rd_ptr_reg <= 1'b0;
            o_cnt_reg    <= '0;
        end else begin
            if (b1_valid_reg) begin
                o_wr_ptr_reg <= !o_wr_ptr_reg;
            end
            if (take) begin
                o_rd_ptr_reg <= !o_rd_ptr_reg;
            end
            o_cnt_reg <= o_cnt_next;
        end
    end

    assign m_tvalid = (o_cnt_reg != '0);
    assign m_tdata  = {{PAD_W{1'b0}},
                       obuf_reg[o_rd_ptr_reg].hd,
                       obuf_reg[o_rd_ptr_reg].wd,
                       obuf_reg[o_rd_ptr_reg].sy,
                       obuf_reg[o_rd_ptr_reg].sx,
                       obuf_reg[o_rd_ptr_reg].pixel};
    assign m_tuser  = obuf_reg[o_rd_ptr_reg].in_src;

endmodule

@@ sv/image_rotation_mapper.sv @@
// ----------------------------------------------------------------------------
// image_rotation_mapper - nearest-neighbor image rotation by inverse mapping
// Loads source pixels into a 256 x 256 RGB888 frame store and answers fetches
// of destination pixels with the rotated source pixel or white.
// ----------------------------------------------------------------------------
// One beat is accepted every clock while s_tready is high, and one result beat
// leaves per input beat, in order. Write beats (tuser 0) store a pixel inside
// width and height; fetch beats (tuser 1) map the destination point back
// through the cos/sin registers (Q2.14) with ceiling rounding and return the
// stored pixel, or 0xFFFFFF outside the source image. A result beat passes
// five mapping stages, the command queue, the frame-store read and the output
// buffer. Write cos, sin, width and height only while no beat is in flight;
// the derived destination size settles through the product and then the size
// registers after the last register write. The frame store is not cleared:
// fetch only pixels that were written.
// ----------------------------------------------------------------------------
module image_rotation_mapper (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [irm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [irm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [8:0] coord_x, [17:9] coord_y, [41:18] pixel_in, [47:42] zero
    input  logic [irm_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] operation
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [23:0] pixel_out, [34:24] source_x, [45:35] source_y,
    // [55:46] dest_width, [65:56] dest_height, [71:66] zero
    output logic [irm_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] inside_res
    output logic                             m_tuser
);

    logic                          q_push, q_pop, q_valid;
    irm_pkg::cmd_t                 q_push_cmd, q_head;
    logic [irm_pkg::QCNT_W-1:0]    q_count;

    irm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd)
    );

    irm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head),
        .count      (q_count)
    );

    irm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
